// ===== rtl/core/slab_free_list_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// Slab free-list allocator assertion macros
// Shorthand for the concurrent checks used by the allocator checker.
// ----------------------------------------------------------------------------
`ifndef SLAB_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define SLAB_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Check that ante implies cons in the same cycle
`define SFLA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that ante implies cons in the next cycle
`define SFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sfla_pkg.sv =====
// ----------------------------------------------------------------------------
// Slab free-list allocator package
// Field widths, status and function codes, register indexes and link types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfla_pkg;

    localparam int SLOT_W     = 8;
    localparam int LINK_W     = 9;
    localparam int OBJ_W      = 13;
    localparam int COUNT_W    = 9;
    localparam int OFS_W      = 21;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [OBJ_W-1:0]   OBJ_MAX     = 13'd4096;
    localparam logic [OBJ_W-1:0]   OBJ_RESET   = 13'd64;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_OBJECT_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_HEAD  = 2'd3
    } status_t;

    typedef enum logic {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } func_t;

    // Requests from the allocator core to the link store
    typedef struct packed {
        logic              clear;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic [LINK_W-1:0] wr_data;
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
    } link_req_t;

endpackage

// ===== rtl/core/sfla_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfla_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/sfla_link_store.sv =====
// ----------------------------------------------------------------------------
// Slab free-list link store
// Next-slot links in a RAM, with a valid bit per entry so that an entry never
// written since the last rebuild reads as its index plus one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfla_link_store #(
    parameter int DEPTH = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sfla_pkg::link_req_t             req,
    output logic [sfla_pkg::LINK_W-1:0]     rd_data
);

    localparam int AW = $clog2(DEPTH);

    logic [DEPTH-1:0]              valid_reg;
    logic [DEPTH-1:0]              valid_next;
    logic                          rd_hit_reg;
    logic [AW-1:0]                 rd_addr_reg;
    logic [sfla_pkg::LINK_W-1:0]   ram_q;

    sfla_ram #(
        .WIDTH (sfla_pkg::LINK_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (req.wr_en),
        .waddr (req.wr_addr[AW-1:0]),
        .wdata (req.wr_data),
        .re    (req.rd_en),
        .raddr (req.rd_addr[AW-1:0]),
        .rdata (ram_q)
    );

    // Drop all valid bits on rebuild, mark entries as they are written
    always_comb
    begin
        valid_next = valid_reg;
        if (req.clear)
        begin
            valid_next = '0;
        end
        else if (req.wr_en)
        begin
            valid_next[req.wr_addr[AW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_hit_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.rd_en)
            begin
                rd_hit_reg <= valid_reg[req.rd_addr[AW-1:0]];
            end
        end
    end

    // Hold the read address for the default link
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_addr_reg <= req.rd_addr[AW-1:0];
        end
    end

    assign rd_data = rd_hit_reg ? ram_q
                   : sfla_pkg::LINK_W'(rd_addr_reg) + sfla_pkg::LINK_W'(1);

endmodule

// ===== rtl/core/slab_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// Slab free-list allocator
// Hands out and takes back fixed-size slots kept as a linked free list.
//
//   Channel | Signals                               | Direction
//   req     | req_valid req_ready func slot         | in
//   rsp     | rsp_valid rsp_ready status            | out
//           | granted_slot data_offset              |
//   cfg     | cfg_we cfg_index cfg_wdata            | in
//
// One request per cycle sustained while responses are taken; a response
// passes the input register and the result register after the request
// transfer. The head link is prefetched from the link RAM on every successful
// allocate, so its RAM read is hidden behind the next request. Reset and
// every configuration write rebuild the list by dropping the link valid bits.
// A stalled response holds one more request in the input register, then req_ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module slab_free_list_allocator #(
    parameter int MAX_SLOTS    = 256,
    parameter int HEADER_BYTES = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  logic                                func,
    input  logic [sfla_pkg::SLOT_W-1:0]         slot,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output logic [1:0]                          status,
    output logic [sfla_pkg::SLOT_W-1:0]         granted_slot,
    output logic [sfla_pkg::OFS_W-1:0]          data_offset,
    input  logic                                cfg_we,
    input  logic [sfla_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sfla_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // Only the first 256 slots are reachable through the slot field
    localparam int DEPTH = (MAX_SLOTS > 256) ? 256 : MAX_SLOTS;
    localparam logic [sfla_pkg::COUNT_W-1:0] DEPTH_N = sfla_pkg::COUNT_W'(DEPTH);
    localparam logic [sfla_pkg::OBJ_W-1:0]   HDR     = sfla_pkg::OBJ_W'(HEADER_BYTES);

    // Configuration
    logic [sfla_pkg::OBJ_W-1:0]   object_size_reg, object_size_next;
    logic [sfla_pkg::COUNT_W-1:0] slot_count_reg, slot_count_next;
    logic                         cfg_hit;

    // Input register
    logic                         s1_valid_reg, s1_valid_next;
    sfla_pkg::func_t              s1_func_reg;
    logic [sfla_pkg::SLOT_W-1:0]  s1_slot_reg;

    // List state
    logic [sfla_pkg::LINK_W-1:0]  head_reg, head_next;
    logic [sfla_pkg::COUNT_W-1:0] used_reg, used_next;
    logic [sfla_pkg::LINK_W-1:0]  head_link_reg, head_link_next;
    logic                         link_from_ram_reg, link_from_ram_next;

    // Result register
    logic                         rsp_valid_reg, rsp_valid_next;
    sfla_pkg::status_t            status_reg, status_next;
    logic [sfla_pkg::SLOT_W-1:0]  granted_reg, granted_next;
    logic [sfla_pkg::OFS_W-1:0]   offset_reg, offset_next;

    // Datapath
    logic                         fire;
    logic [sfla_pkg::COUNT_W-1:0] n_eff;
    logic [sfla_pkg::OBJ_W-1:0]   osz;
    logic [sfla_pkg::OBJ_W-1:0]   stride;
    logic [sfla_pkg::LINK_W-1:0]  cur_link;
    logic [sfla_pkg::LINK_W-1:0]  link_rd_data;
    logic [sfla_pkg::LINK_W-1:0]  free_slot;
    sfla_pkg::link_req_t          link_req;

    sfla_link_store #(
        .DEPTH (DEPTH)
    ) u_links (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (link_req),
        .rd_data (link_rd_data)
    );

    // Handshake: process when the result register is free or drains now
    assign fire      = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !s1_valid_reg || fire;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (req_valid && req_ready)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Clamp configuration and pick the current head link
    assign n_eff     = (slot_count_reg > DEPTH_N) ? DEPTH_N : slot_count_reg;
    assign osz       = (object_size_reg > sfla_pkg::OBJ_MAX) ? sfla_pkg::OBJ_MAX
                     : object_size_reg;
    assign stride    = osz + HDR;
    assign cur_link  = link_from_ram_reg ? link_rd_data : head_link_reg;
    assign free_slot = sfla_pkg::LINK_W'(s1_slot_reg);

    // Allocate or free against the list, then apply configuration writes
    always_comb
    begin
        status_next        = status_reg;
        granted_next       = granted_reg;
        offset_next        = offset_reg;
        head_next          = head_reg;
        used_next          = used_reg;
        head_link_next     = head_link_reg;
        link_from_ram_next = link_from_ram_reg;
        object_size_next   = object_size_reg;
        slot_count_next    = slot_count_reg;
        link_req           = '0;
        cfg_hit            = 1'b0;

        if (fire)
        begin
            status_next  = sfla_pkg::ST_OK;
            granted_next = '0;
            offset_next  = '0;
            case (s1_func_reg)
                sfla_pkg::FN_ALLOC:
                begin
                    if ((used_reg >= n_eff) || (head_reg >= n_eff))
                    begin
                        status_next = sfla_pkg::ST_FULL;
                    end
                    else
                    begin
                        granted_next       = head_reg[sfla_pkg::SLOT_W-1:0];
                        offset_next        = sfla_pkg::OFS_W'(head_reg[sfla_pkg::SLOT_W-1:0])
                                           * sfla_pkg::OFS_W'(stride)
                                           + sfla_pkg::OFS_W'(HDR);
                        head_next          = cur_link;
                        used_next          = used_reg + sfla_pkg::COUNT_W'(1);
                        // Prefetch the link of the new head
                        link_req.rd_en     = 1'b1;
                        link_req.rd_addr   = cur_link[sfla_pkg::SLOT_W-1:0];
                        link_from_ram_next = 1'b1;
                    end
                end
                sfla_pkg::FN_FREE:
                begin
                    if ((free_slot >= n_eff) || (used_reg == '0))
                    begin
                        status_next = sfla_pkg::ST_EMPTY;
                    end
                    else if (free_slot == head_reg)
                    begin
                        status_next = sfla_pkg::ST_HEAD;
                    end
                    else
                    begin
                        // Push: freed slot links to the old head
                        link_req.wr_en     = 1'b1;
                        link_req.wr_addr   = s1_slot_reg;
                        link_req.wr_data   = head_reg;
                        head_next          = free_slot;
                        head_link_next     = head_reg;
                        link_from_ram_next = 1'b0;
                        used_next          = used_reg - sfla_pkg::COUNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = sfla_pkg::ST_OK;
                end
            endcase
        end

        if (cfg_we)
        begin
            case (cfg_index)
                sfla_pkg::REG_OBJECT_SIZE:
                begin
                    object_size_next = cfg_wdata;
                    cfg_hit          = 1'b1;
                end
                sfla_pkg::REG_SLOT_COUNT:
                begin
                    slot_count_next = cfg_wdata[sfla_pkg::COUNT_W-1:0];
                    cfg_hit         = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end

        // Rebuild the list: head at slot 0, slot 0 links to slot 1
        if (cfg_hit)
        begin
            head_next          = '0;
            used_next          = '0;
            head_link_next     = sfla_pkg::LINK_W'(1);
            link_from_ram_next = 1'b0;
            link_req.clear     = 1'b1;
        end
    end

    // Control and list state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            object_size_reg   <= sfla_pkg::OBJ_RESET;
            slot_count_reg    <= sfla_pkg::COUNT_RESET;
            s1_valid_reg      <= 1'b0;
            rsp_valid_reg     <= 1'b0;
            head_reg          <= '0;
            used_reg          <= '0;
            head_link_reg     <= sfla_pkg::LINK_W'(1);
            link_from_ram_reg <= 1'b0;
        end
        else
        begin
            object_size_reg   <= object_size_next;
            slot_count_reg    <= slot_count_next;
            s1_valid_reg      <= s1_valid_next;
            rsp_valid_reg     <= rsp_valid_next;
            head_reg          <= head_next;
            used_reg          <= used_next;
            head_link_reg     <= head_link_next;
            link_from_ram_reg <= link_from_ram_next;
        end
    end

    // Payload: capture the request, hold the result
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            s1_func_reg <= sfla_pkg::func_t'(func);
            s1_slot_reg <= slot;
        end
        status_reg  <= status_next;
        granted_reg <= granted_next;
        offset_reg  <= offset_next;
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign granted_slot = granted_reg;
    assign data_offset  = offset_reg;

endmodule

// ===== rtl/core/sfla_checker.sv =====
// ----------------------------------------------------------------------------
// Slab free-list allocator checker
// Port-level checks on response contents, latency and backpressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "slab_free_list_allocator_defines.svh"

module sfla_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    input  logic                                req_ready,
    input  logic                                rsp_valid,
    input  logic                                rsp_ready,
    input  logic [1:0]                          status,
    input  logic [sfla_pkg::SLOT_W-1:0]         granted_slot,
    input  logic [sfla_pkg::OFS_W-1:0]          data_offset
);

    // A rejected request carries no slot and no offset
    `SFLA_ASSERT_IMP(a_reject_zero, rsp_valid && (status != sfla_pkg::ST_OK), (granted_slot == '0) && (data_offset == '0), "rejected response carries a slot or offset")

    // A new response follows a request transfer through the input and result registers
    `SFLA_ASSERT_IMP(a_rsp_latency, $rose(rsp_valid), $past(req_valid && req_ready, 2), "response without a matching request")

    // Two requests in flight under a stalled response close the input
    `SFLA_ASSERT_IMP(a_full_stall, $past(rsp_valid && !rsp_ready) && $past(req_valid && req_ready) && rsp_valid && !rsp_ready, !req_ready, "request taken with both stages full")

    // A stalled response holds its contents
    `SFLA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(granted_slot) && $stable(data_offset), "stalled response changed")

endmodule

bind slab_free_list_allocator sfla_checker u_sfla_checker (.*);

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// Slab free-list allocator testbench
// Drives allocate and free requests with random gaps and response stalls.
// A scoreboard class keeps its own copy of the free list and the counters,
// predicts status, granted slot and data offset for each request transfer,
// and compares every response transfer in order. Each phase reconfigures
// the object size and the slot count while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import sfla_pkg::*;

    localparam int SLAB_SLOTS  = 256;
    localparam int HDR_BYTES   = 24;
    localparam int IDLE_LIMIT  = 4000;

    typedef struct packed {
        status_t           status;
        logic [SLOT_W-1:0] slot;
        logic [OFS_W-1:0]  offset;
    } alloc_result_t;

    // Free-list predictor and in-order result checker
    class slab_scoreboard;
        logic [LINK_W-1:0]  link_mem [SLAB_SLOTS];
        logic [LINK_W-1:0]  head;
        logic [COUNT_W-1:0] used;
        logic [OBJ_W-1:0]   obj_size;
        logic [COUNT_W-1:0] slot_cnt;
        alloc_result_t      pending [$];
        int                 held [$];
        int                 errors;
        int                 checked;

        function new();
            obj_size = OBJ_RESET;
            slot_cnt = COUNT_RESET;
            errors   = 0;
            checked  = 0;
            rebuild();
        endfunction

        function void rebuild();
            for (int i = 0; i < SLAB_SLOTS; i++)
            begin
                link_mem[i] = LINK_W'(i + 1);
            end
            head = '0;
            used = '0;
            held.delete();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_OBJECT_SIZE)
                obj_size = data[OBJ_W-1:0];
            else
                slot_cnt = data[COUNT_W-1:0];
            rebuild();
        endfunction

        task report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        // Advance the free list for one accepted request and queue its result
        function void note_request(func_t fn, logic [SLOT_W-1:0] s);
            alloc_result_t r;
            int unsigned   n;
            int unsigned   osz;
            n        = (slot_cnt > SLAB_SLOTS) ? SLAB_SLOTS : slot_cnt;
            r.status = ST_OK;
            r.slot   = '0;
            r.offset = '0;
            if (fn == FN_ALLOC)
            begin
                if (used >= n || head >= n)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    osz      = (obj_size > OBJ_MAX) ? OBJ_MAX : obj_size;
                    r.slot   = head[SLOT_W-1:0];
                    r.offset = OFS_W'(int'(head) * (osz + HDR_BYTES) + HDR_BYTES);
                    held.push_back(int'(head));
                    head     = link_mem[head[SLOT_W-1:0]];
                    used     = used + 1'b1;
                end
            end
            else
            begin
                if (s >= n || used == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else if (LINK_W'(s) == head)
                begin
                    r.status = ST_HEAD;
                end
                else
                begin
                    link_mem[s] = head;
                    head        = LINK_W'(s);
                    used        = used - 1'b1;
                    // drop one copy from the list of slots out on loan
                    for (int i = 0; i < held.size(); i++)
                    begin
                        if (held[i] == int'(s))
                        begin
                            held.delete(i);
                            break;
                        end
                    end
                end
            end
            pending.push_back(r);
        endfunction

        task check_response(logic [1:0] st, logic [SLOT_W-1:0] gs,
                            logic [OFS_W-1:0] ofs);
            alloc_result_t w;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result status=%0d slot=%0d offset=%0d",
                                 st, gs, ofs));
                return;
            end
            w = pending.pop_front();
            if (st !== w.status || gs !== w.slot || ofs !== w.offset)
                report($sformatf("result %0d: status %0d/%0d slot %0d/%0d offset %0d/%0d",
                                 checked, st, w.status, gs, w.slot, ofs, w.offset));
            checked++;
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    logic                  func;
    logic [SLOT_W-1:0]     slot;
    logic                  rsp_valid;
    logic                  rsp_ready;
    logic [1:0]            status;
    logic [SLOT_W-1:0]     granted_slot;
    logic [OFS_W-1:0]      data_offset;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    slab_scoreboard sb;
    int             idle_cycles = 0;
    int             calm_left   = 0;

    slab_free_list_allocator #(
        .MAX_SLOTS    (SLAB_SLOTS),
        .HEADER_BYTES (HDR_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .func         (func),
        .slot         (slot),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .status       (status),
        .granted_slot (granted_slot),
        .data_offset  (data_offset),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    always #4 clk = ~clk;

    // Note request transfers before checking responses in the same cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_request(func_t'(func), slot);
            if (rsp_valid && rsp_ready)
                sb.check_response(status, granted_slot, data_offset);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Stall the response side: long ready stretches, short and long stalls
    initial
    begin
        int r;
        int len;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            r = $urandom_range(0, 99);
            if (r < 50)
            begin
                rsp_ready <= 1'b1;
                len = $urandom_range(1, 40);
            end
            else if (r < 88)
            begin
                rsp_ready <= 1'b0;
                len = $urandom_range(1, 3);
            end
            else
            begin
                rsp_ready <= 1'b0;
                len = $urandom_range(6, 20);
            end
            repeat (len - 1) @(negedge clk);
        end
    end

    // End the run when nothing transfers for too long
    initial
    begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        $display("simulation failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 20);
    endfunction

    // Present one request after an optional gap; hold until transfer
    task automatic send_request(func_t fn, logic [SLOT_W-1:0] s, int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        func      <= fn;
        slot      <= s;
        do
            @(posedge clk);
        while (!req_ready);
        @(negedge clk);
    endtask

    // Wait for all outstanding results, with the request valid dropped
    task automatic wait_drained();
        req_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic reconfigure(int obj, int cnt);
        wait_drained();
        cfg_write(REG_OBJECT_SIZE, CFG_DATA_W'(obj));
        cfg_write(REG_SLOT_COUNT, CFG_DATA_W'(cnt));
        cfg_we <= 1'b0;
    endtask

    // Mostly allocations and frees of held slots, with some noise
    task automatic run_phase(int obj, int cnt, int items, int alloc_pct);
        int                r;
        func_t             fn;
        logic [SLOT_W-1:0] s;
        reconfigure(obj, cnt);
        for (int k = 0; k < items; k++)
        begin
            r = $urandom_range(0, 99);
            s = SLOT_W'($urandom_range(0, 255));
            if (r < 8)
            begin
                fn = ($urandom_range(0, 1) != 0) ? FN_FREE : FN_ALLOC;
                if (r < 3 && sb.head < SLAB_SLOTS)
                begin
                    fn = FN_FREE;
                    s  = sb.head[SLOT_W-1:0];
                end
            end
            else if (r < alloc_pct)
            begin
                fn = FN_ALLOC;
            end
            else
            begin
                fn = FN_FREE;
                if (sb.held.size() > 0)
                    s = SLOT_W'(sb.held[$urandom_range(0, sb.held.size() - 1)]);
            end
            send_request(fn, s, pick_gap());
        end
    endtask

    initial
    begin
        sb        = new();
        rst_n     = 1'b0;
        req_valid = 1'b0;
        func      = FN_ALLOC;
        slot      = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_OBJECT_SIZE;
        cfg_wdata = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset configuration: empty free, head reject, caught double free, undetected free of an unheld slot
        send_request(FN_FREE, 8'd5, 0);
        send_request(FN_ALLOC, 8'hFF, 0);
        send_request(FN_ALLOC, 8'h00, 1);
        send_request(FN_FREE, 8'd2, 0);
        send_request(FN_FREE, 8'd0, 0);
        send_request(FN_FREE, 8'd0, 2);
        send_request(FN_FREE, 8'd255, 0);
        send_request(FN_ALLOC, 8'd0, 0);

        // Two slots, zero payload: full slab and out-of-range free
        reconfigure(0, 2);
        send_request(FN_ALLOC, 8'd0, 0);
        send_request(FN_ALLOC, 8'd0, 0);
        send_request(FN_ALLOC, 8'd0, 0);
        send_request(FN_FREE, 8'd2, 0);
        send_request(FN_FREE, 8'd1, 0);
        send_request(FN_FREE, 8'd0, 0);
        send_request(FN_FREE, 8'd1, 0);
        send_request(FN_ALLOC, 8'd0, 0);

        // Slot count that masks to zero: empty slab
        reconfigure(13'h1FFF, 13'h1E00);
        send_request(FN_ALLOC, 8'd0, 0);
        send_request(FN_FREE, 8'd0, 0);

        // Random phases over a spread of settings, extremes included
        run_phase(13'h1FFF, 13'h1FFF, 330, 95);
        run_phase(0, 1, 100, 50);
        run_phase(1, 256, 150, 60);
        run_phase(4096, 4, 200, 55);
        run_phase($urandom_range(1, 8191), $urandom_range(1, 40), 200, 55);
        run_phase(37, 16, 200, 50);
        run_phase(4097, 255, 80, 70);

        wait_drained();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== slab_free_list_allocator.f =====
+incdir+rtl/core
rtl/core/sfla_pkg.sv
rtl/core/sfla_ram.sv
rtl/core/sfla_link_store.sv
rtl/core/slab_free_list_allocator.sv
rtl/core/sfla_checker.sv
sim/tb.sv
